@@ src/sawarq_pkg.sv @@
// shared types, constants and the id compare mask for the stop-and-wait arq controller
// no dependencies; the cfg regs, core and top import this package
`timescale 1ns / 1ps

package sawarq_pkg;

  // number of leading id bytes that take part in the ack compare
  localparam int unsigned IdBytes = 6;
  localparam int unsigned IdWidth = 48;
  localparam int unsigned TimeWidth = 32;
  localparam int unsigned TimeoutWidth = 16;
  localparam int unsigned RetryLimWidth = 4;
  localparam int unsigned RetryCntWidth = 5;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [TimeoutWidth-1:0] AckTimeoutReset = 16'd1500;
  localparam logic [RetryLimWidth-1:0] MaxRetriesReset = 4'd3;

  typedef enum logic [1:0] {
    ActSend = 2'd0,
    ActAck  = 2'd1,
    ActTick = 2'd2
  } action_e;

  typedef enum logic {
    CfgAckTimeout = 1'b0,
    CfgMaxRetries = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    action_e              action;
    logic [IdWidth-1:0]   pkt_id;
    logic [TimeWidth-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic accepted;
    logic transmit;
    logic failed;
    logic pending;
  } out_item_t;

  typedef struct packed {
    logic [TimeoutWidth-1:0]  ack_timeout_ms;
    logic [RetryLimWidth-1:0] max_retries;
  } cfg_t;

  // leading bytes set; six or more bytes compare the whole id
  function automatic logic [IdWidth-1:0] id_mask_f(input int unsigned n_bytes);
    logic [IdWidth-1:0] mask;
    mask = '0;
    for (int unsigned b = 0; b < IdWidth / 8; b++) begin
      if (b < n_bytes) begin
        mask[IdWidth-1-8*b -: 8] = 8'hFF;
      end
    end
    return mask;
  endfunction

  localparam logic [IdWidth-1:0] IdMask = id_mask_f(IdBytes);

endpackage

@@ src/sawarq_ifs.sv @@
// valid/ready channel interfaces for event items in and result items out
// depends on nothing; field widths match sawarq_pkg
`timescale 1ns / 1ps

interface sawarq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [47:0] pkt_id;
  logic [31:0] now_ms;

  modport source (output valid, action, pkt_id, now_ms, input ready);
  modport sink (input valid, action, pkt_id, now_ms, output ready);
endinterface

interface sawarq_out_if;
  logic valid;
  logic ready;
  logic accepted;
  logic transmit;
  logic failed;
  logic pending;

  modport source (output valid, accepted, transmit, failed, pending, input ready);
  modport sink (input valid, accepted, transmit, failed, pending, output ready);
endinterface

@@ src/sawarq_cfg_regs.sv @@
// configuration registers: ack timeout and retry limit, written by index
// depends on sawarq_pkg
`timescale 1ns / 1ps

module sawarq_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [sawarq_pkg::CfgDataWidth-1:0]   cfg_wdata_i,
  output sawarq_pkg::cfg_t                      cfg_o
);
  import sawarq_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgAckTimeout: cfg_d.ack_timeout_ms = cfg_wdata_i[TimeoutWidth-1:0];
        CfgMaxRetries: cfg_d.max_retries = cfg_wdata_i[RetryLimWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_timeout_ms <= AckTimeoutReset;
      cfg_q.max_retries <= MaxRetriesReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/sawarq_core.sv @@
// protocol state (busy, retry count, deadline, held id) and the per-event update
// depends on sawarq_pkg
`timescale 1ns / 1ps

module sawarq_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  sawarq_pkg::in_item_t   item_i,
  input  sawarq_pkg::cfg_t       cfg_i,
  output sawarq_pkg::out_item_t  res_o
);
  import sawarq_pkg::*;

  logic                     busy_q, busy_d;
  logic [RetryCntWidth-1:0] retry_q, retry_d;
  logic [TimeWidth-1:0]     deadline_q, deadline_d;
  logic [IdWidth-1:0]       held_id_q, held_id_d;

  logic [TimeWidth-1:0]     arm_time;
  logic [RetryCntWidth-1:0] retry_inc;
  logic                     id_match;
  out_item_t                res;

  assign arm_time = item_i.now_ms + {{(TimeWidth-TimeoutWidth){1'b0}}, cfg_i.ack_timeout_ms};
  assign retry_inc = retry_q + RetryCntWidth'(1);
  assign id_match = ((held_id_q ^ item_i.pkt_id) & IdMask) == '0;

  always_comb begin
    busy_d = busy_q;
    retry_d = retry_q;
    deadline_d = deadline_q;
    held_id_d = held_id_q;
    res = '0;
    case (item_i.action)
      ActSend: begin
        if (!busy_q) begin
          held_id_d = item_i.pkt_id;
          retry_d = '0;
          deadline_d = '0;
          busy_d = 1'b1;
          res.accepted = 1'b1;
          res.transmit = 1'b1;
        end
      end
      ActAck: begin
        if (busy_q && id_match) begin
          busy_d = 1'b0;
          res.accepted = 1'b1;
        end
      end
      ActTick: begin
        if (busy_q) begin
          // zero deadline means not armed yet
          if (deadline_q == '0) begin
            deadline_d = arm_time;
          end else if (item_i.now_ms >= deadline_q) begin
            retry_d = retry_inc;
            if (retry_inc > {1'b0, cfg_i.max_retries}) begin
              busy_d = 1'b0;
              res.failed = 1'b1;
            end else begin
              deadline_d = arm_time;
              res.accepted = 1'b1;
              res.transmit = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    res.pending = busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      retry_q <= '0;
      deadline_q <= '0;
      held_id_q <= '0;
    end else if (advance_i) begin
      busy_q <= busy_d;
      retry_q <= retry_d;
      deadline_q <= deadline_d;
      held_id_q <= held_id_d;
    end
  end

  assign res_o = res;

endmodule

@@ src/stop_and_wait_arq_controller_top.sv @@
// stop-and-wait arq sender controller: event register, state update, result register
// the result register captures a result when its event item moves out of the event register
// throughput: one item per cycle unless out stalls; the state update is a few adds and compares
// reset clears busy, retry count, deadline and held id, and loads the default timeout and limit
// depends on sawarq_pkg, sawarq_ifs, sawarq_cfg_regs, sawarq_core
`timescale 1ns / 1ps

module stop_and_wait_arq_controller_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  sawarq_in_if.sink                           in_i,
  sawarq_out_if.source                        out_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [sawarq_pkg::CfgDataWidth-1:0] cfg_wdata_i
);
  import sawarq_pkg::*;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      advance;
  logic      in_ready;
  cfg_t      cfg;
  out_item_t res;

  // the event register moves on whenever the result slot is free or being drained
  assign advance = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_q.action <= action_e'(in_i.action);
      in_q.pkt_id <= in_i.pkt_id;
      in_q.now_ms <= in_i.now_ms;
    end
  end

  sawarq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sawarq_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.accepted = out_q.accepted;
  assign out_o.transmit = out_q.transmit;
  assign out_o.failed = out_q.failed;
  assign out_o.pending = out_q.pending;

  // giving up a packet always leaves the controller idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.failed |-> !out_q.pending && !out_q.transmit)
    else $error("failed result still pending or transmitting");

  // every transmission request leaves a packet outstanding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.transmit |-> out_q.accepted && out_q.pending)
    else $error("transmit without accept or pending");

  // a stalled event item is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("stalled event item lost");

endmodule
